// File: rtl/core/mpp_pkg.sv
// Shared types and codes of the metric payload parser.
// Input beat, result beat and run buffer types; no dependencies.
package mpp_pkg;

  localparam int RunSlots = 3;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_NAME   = 3'd1;
  localparam logic [2:0] KIND_VALUE  = 3'd2;
  localparam logic [2:0] KIND_METRIC = 3'd3;
  localparam logic [2:0] KIND_PACKET = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic ERR_LENGTH = 1'b0;
  localparam logic ERR_COUNT  = 1'b1;

  localparam logic [7:0] CFG_MAX_METRIC_COUNT = 8'd0;
  localparam logic [7:0] CFG_MIN_PACKET_BYTES = 8'd1;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        packet_start;
    logic [16:0] bytes_left;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  byte_out;
    logic        alias_used;
    logic [63:0] alias_or_seq;
    logic [31:0] type_code;
    logic [63:0] value_bits;
    logic        value_present;
    logic        is_null;
    logic [15:0] metric_total;
    logic        error_code;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]           cnt;
    out_t [RunSlots-1:0]  slot;
  } run_t;

endpackage

// File: rtl/core/metric_payload_parser_top.sv
// Top level of the metric payload parser.
// Depends on mpp_pkg, mpp_parser and mpp_run_buf.
//
// Usage:
//   in_*  : one packet byte per beat, tagged with packet_start and bytes_left.
//   out_* : one result per beat (header, name byte, value byte, metric done,
//           packet done, error); last_of_run marks the final result of a byte.
//   cfg_* : register writes (index 0 max_metric_count, index 1
//           min_packet_bytes); cfg_ready is always high. Write only when idle.
// Latency: the first result of a byte shows on out_* the cycle after the beat.
// Throughput: one byte per cycle while each byte yields at most one result
//   and out_stall is low; a byte that yields k results (k up to 3) raises
//   in_stall until the single result port, draining the run buffer one beat
//   a cycle, reaches the last result of that byte.
// Stall: while out_stall is high the current result holds, and in_stall
//   rises once the run buffer cannot take the next byte's results.
// Reset: synchronous, active low; drop any pending results, return the parser
//   to idle and restore the register defaults (10000 metrics, 24 bytes).
module metric_payload_parser_top #(
  parameter int MAX_PACKET_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mpp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mpp_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import mpp_pkg::*;

  run_t run;
  logic can_load;
  logic accept;

  // Take a beat only when the run buffer has room for all of its results.
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;
  assign cfg_ready = 1'b1;

  mpp_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .run       (run)
  );

  mpp_run_buf u_run_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .run       (run),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/mpp_parser.sv
// Parse state, configuration registers and the per-beat decode logic.
// Depends on mpp_pkg; produces the run of results for each accepted beat.
module mpp_parser #(
  parameter int MAX_PACKET_BYTES = 65536
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  mpp_pkg::in_t    in_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output mpp_pkg::run_t   run
);
  import mpp_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0, PH_TS = 4'd1, PH_SEQ = 4'd2, PH_COUNT = 4'd3,
                         PH_FLAG = 4'd4, PH_ALIAS = 4'd5, PH_NAMELEN = 4'd6,
                         PH_NAME = 4'd7, PH_TYPE = 4'd8, PH_SCALAR = 4'd9,
                         PH_SLEN = 4'd10, PH_SDATA = 4'd11;
  localparam logic [24:0] MaxBytes = 25'(MAX_PACKET_BYTES);

  logic [15:0] max_cnt_r;
  logic [7:0]  min_bytes_r;
  logic [3:0]  ph_r, ph_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [16:0] tg_r, tg_nxt;
  logic [63:0] ts_r, ts_nxt, sq_r, sq_nxt, ma_r, ma_nxt;
  logic [15:0] mexp_r, mexp_nxt, mseen_r, mseen_nxt;
  logic        af_r, af_nxt;
  logic [31:0] mt_r, mt_nxt;

  function automatic logic [3:0] scalar_size(input logic [31:0] t);
    case (t)
      32'd1, 32'd5, 32'd11: scalar_size = 4'd1;
      32'd2, 32'd6:         scalar_size = 4'd2;
      32'd3, 32'd7, 32'd9:  scalar_size = 4'd4;
      32'd4, 32'd8, 32'd10: scalar_size = 4'd8;
      default:              scalar_size = 4'd0;
    endcase
  endfunction

  function automatic logic [63:0] scalar_bits(input logic [31:0] t, input logic [63:0] v);
    case (t)
      32'd1:   scalar_bits = {{56{v[7]}}, v[7:0]};
      32'd2:   scalar_bits = {{48{v[15]}}, v[15:0]};
      32'd3:   scalar_bits = {{32{v[31]}}, v[31:0]};
      32'd11:  scalar_bits = {63'd0, v != 64'd0};
      default: scalar_bits = v;
    endcase
  endfunction

  function automatic out_t mk(input logic [2:0] kind, input logic [7:0] b,
                              input logic au, input logic [63:0] aos,
                              input logic [31:0] t, input logic [63:0] bits,
                              input logic pres, input logic nul,
                              input logic [15:0] cnt, input logic err);
    out_t o;
    o.result_kind = kind;  o.byte_out = b;       o.alias_used = au;
    o.alias_or_seq = aos;  o.type_code = t;      o.value_bits = bits;
    o.value_present = pres; o.is_null = nul;     o.metric_total = cnt;
    o.error_code = err;    o.last_of_run = 1'b0;
    mk = o;
  endfunction

  always_comb begin
    logic [16:0] rem, after, tg_dec;
    logic [63:0] shn;
    logic [3:0]  sz;
    logic [1:0]  n;
    logic        skip, do_stype, do_mdone, do_next, do_pdone;
    logic [63:0] md_bits;
    logic        md_pres, md_null;
    out_t        e;
    out_t [RunSlots-1:0] slots;

    ph_nxt = ph_r;  sh_nxt = sh_r;  tg_nxt = tg_r;  ts_nxt = ts_r;  sq_nxt = sq_r;
    mexp_nxt = mexp_r;  mseen_nxt = mseen_r;  af_nxt = af_r;  ma_nxt = ma_r;  mt_nxt = mt_r;
    slots = '0;  n = 2'd0;  skip = 1'b0;  e = '0;
    do_stype = 1'b0;  do_mdone = 1'b0;  do_next = 1'b0;  do_pdone = 1'b0;
    md_bits = '0;  md_pres = 1'b0;  md_null = 1'b0;
    rem = (in_data.bytes_left == 17'd0) ? 17'd1 : in_data.bytes_left;
    after = rem - 17'd1;
    shn = {sh_r[55:0], in_data.byte_value};
    tg_dec = tg_r - 17'd1;
    sz = 4'd0;

    if (in_data.packet_start) begin
      if (rem < {9'd0, min_bytes_r} || {8'd0, rem} > MaxBytes) begin
        e = mk(KIND_ERROR, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, ERR_LENGTH);
        slots[n] = e;  n = n + 2'd1;
        ph_nxt = PH_IDLE;
        skip = 1'b1;
      end else begin
        ph_nxt = PH_TS;  sh_nxt = '0;  tg_nxt = 17'd8;
        mexp_nxt = '0;  mseen_nxt = '0;
      end
    end

    if (!skip && ph_nxt != PH_IDLE) begin
      // A start beat always lands in the timestamp phase with a fresh field.
      if (in_data.packet_start) begin
        shn = {56'd0, in_data.byte_value};
        tg_dec = 17'd7;
      end
      unique case (ph_nxt)
        PH_FLAG: begin
          af_nxt = in_data.byte_value != 8'd0;
          ma_nxt = '0;  mt_nxt = '0;
          if (af_nxt) begin
            if (after < 17'd8) do_pdone = 1'b1;
            else begin ph_nxt = PH_ALIAS; sh_nxt = '0; tg_nxt = 17'd8; end
          end else begin
            if (after < 17'd4) do_pdone = 1'b1;
            else begin ph_nxt = PH_NAMELEN; sh_nxt = '0; tg_nxt = 17'd4; end
          end
        end
        PH_NAME, PH_SDATA: begin
          e = mk((ph_nxt == PH_NAME) ? KIND_NAME : KIND_VALUE, in_data.byte_value,
                 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
          slots[n] = e;  n = n + 2'd1;
          tg_nxt = tg_dec;
          if (tg_dec == 17'd0) begin
            if (ph_nxt == PH_NAME) do_stype = 1'b1;
            else begin do_mdone = 1'b1; md_pres = 1'b1; end
          end
        end
        default: begin
          sh_nxt = shn;
          tg_nxt = tg_dec;
          if (tg_dec == 17'd0) begin
            unique case (ph_nxt)
              PH_TS: begin
                ts_nxt = shn;  ph_nxt = PH_SEQ;  sh_nxt = '0;  tg_nxt = 17'd8;
              end
              PH_SEQ: begin
                sq_nxt = shn;  ph_nxt = PH_COUNT;  sh_nxt = '0;  tg_nxt = 17'd4;
              end
              PH_COUNT: begin
                if (shn > {48'd0, max_cnt_r}) begin
                  e = mk(KIND_ERROR, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, ERR_COUNT);
                  slots[n] = e;  n = n + 2'd1;
                  ph_nxt = PH_IDLE;
                end else begin
                  mexp_nxt = shn[15:0];  mseen_nxt = '0;
                  e = mk(KIND_HEADER, 8'd0, 1'b0, sq_r, '0, ts_r, 1'b0, 1'b0,
                         shn[15:0], 1'b0);
                  slots[n] = e;  n = n + 2'd1;
                  do_next = 1'b1;
                end
              end
              PH_ALIAS: begin
                ma_nxt = shn;  do_stype = 1'b1;
              end
              PH_NAMELEN: begin
                if (shn == 64'd0 || shn > {47'd0, after}) do_stype = 1'b1;
                else begin ph_nxt = PH_NAME; sh_nxt = '0; tg_nxt = shn[16:0]; end
              end
              PH_TYPE: begin
                mt_nxt = shn[31:0];
                sz = scalar_size(shn[31:0]);
                if (sz != 4'd0) begin
                  if (after < {13'd0, sz}) do_mdone = 1'b1;
                  else begin ph_nxt = PH_SCALAR; sh_nxt = '0; tg_nxt = {13'd0, sz}; end
                end else if (shn[31:0] == 32'd12 || shn[31:0] == 32'd14 ||
                             shn[31:0] == 32'd17) begin
                  if (after < 17'd4) do_mdone = 1'b1;
                  else begin ph_nxt = PH_SLEN; sh_nxt = '0; tg_nxt = 17'd4; end
                end else begin
                  do_mdone = 1'b1;  md_null = 1'b1;
                end
              end
              PH_SCALAR: begin
                do_mdone = 1'b1;  md_pres = 1'b1;
                md_bits = scalar_bits(mt_r, shn);
              end
              PH_SLEN: begin
                if (shn > {47'd0, after}) do_mdone = 1'b1;
                else if (shn == 64'd0) begin do_mdone = 1'b1; md_pres = 1'b1; end
                else begin ph_nxt = PH_SDATA; sh_nxt = '0; tg_nxt = shn[16:0]; end
              end
              default: ph_nxt = PH_IDLE;
            endcase
          end
        end
      endcase

      if (do_stype) begin
        if (after < 17'd4) do_pdone = 1'b1;
        else begin ph_nxt = PH_TYPE; sh_nxt = '0; tg_nxt = 17'd4; end
      end
      if (do_mdone) begin
        e = mk(KIND_METRIC, 8'd0, af_nxt, af_nxt ? ma_nxt : 64'd0, mt_nxt, md_bits,
               md_pres, md_null, '0, 1'b0);
        slots[n] = e;  n = n + 2'd1;
        mseen_nxt = mseen_nxt + 16'd1;
        do_next = 1'b1;
      end
      if (do_next) begin
        if (mseen_nxt >= mexp_nxt || after == 17'd0) do_pdone = 1'b1;
        else ph_nxt = PH_FLAG;
      end
      if (do_pdone) begin
        e = mk(KIND_PACKET, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, mseen_nxt, 1'b0);
        slots[n] = e;  n = n + 2'd1;
        ph_nxt = PH_IDLE;
      end
      // Close the packet when the tag says this was its last byte.
      if (ph_nxt != PH_IDLE && after == 17'd0) begin
        if (ph_nxt == PH_TS || ph_nxt == PH_SEQ || ph_nxt == PH_COUNT)
          e = mk(KIND_ERROR, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, '0, ERR_LENGTH);
        else
          e = mk(KIND_PACKET, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0, mseen_nxt, 1'b0);
        slots[n] = e;  n = n + 2'd1;
        ph_nxt = PH_IDLE;
      end
    end

    if (n != 2'd0) slots[n - 2'd1].last_of_run = 1'b1;
    run.cnt = n;
    run.slot = slots;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cnt_r <= 16'd10000;  min_bytes_r <= 8'd24;
      ph_r <= PH_IDLE;  sh_r <= '0;  tg_r <= '0;  ts_r <= '0;  sq_r <= '0;
      mexp_r <= '0;  mseen_r <= '0;  af_r <= 1'b0;  ma_r <= '0;  mt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_METRIC_COUNT: max_cnt_r <= cfg_data;
          CFG_MIN_PACKET_BYTES: min_bytes_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        ph_r <= ph_nxt;  sh_r <= sh_nxt;  tg_r <= tg_nxt;  ts_r <= ts_nxt;  sq_r <= sq_nxt;
        mexp_r <= mexp_nxt;  mseen_r <= mseen_nxt;  af_r <= af_nxt;  ma_r <= ma_nxt;
        mt_r <= mt_nxt;
      end
    end
  end

endmodule

// File: rtl/core/mpp_run_buf.sv
// Result run buffer: holds the results of one beat and hands them out in order.
// Depends on mpp_pkg.
module mpp_run_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mpp_pkg::run_t  run,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_stall,
  output mpp_pkg::out_t  out_data
);
  import mpp_pkg::*;

  logic [1:0]           cnt_r, cnt_nxt;
  out_t [RunSlots-1:0]  slot_r;
  logic                 pop;

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load)     cnt_nxt = run.cnt;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload: load a whole run, or advance one slot per popped beat.
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= run.slot;
    end else if (pop) begin
      slot_r <= {out_t'('0), slot_r[RunSlots-1:1]};
    end
  end

endmodule
